// ===== design/tlps_pkg.sv =====
// package for the two-level propensity sampler
// holds widths, kind codes and default sizes; no dependencies
package tlps_pkg;
    localparam int DEF_MAX_SPECIES   = 64;
    localparam int DEF_MAX_ROW_LEN   = 16;
    localparam int DEF_MAX_REACTIONS = 1024;

    localparam int VAL_W  = 48;
    localparam int RND_W  = 32;
    localparam int CNT_W  = 32;
    localparam int KIND_W = 3;
    localparam int ROW_W  = 6;
    localparam int COL_W  = 4;
    localparam int REAC_W = 10;
    localparam int CFG_W  = 7;
    localparam int SUM_W  = 64;

    localparam logic [KIND_W-1:0] K_GROUP   = 3'd0;
    localparam logic [KIND_W-1:0] K_PART    = 3'd1;
    localparam logic [KIND_W-1:0] K_COUNT   = 3'd2;
    localparam logic [KIND_W-1:0] K_REAC    = 3'd3;
    localparam logic [KIND_W-1:0] K_LEN     = 3'd4;
    localparam logic [KIND_W-1:0] K_SAMPLE  = 3'd5;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [VAL_W-1:0]  value;
        logic [RND_W-1:0]  random;
    } t_in_beat;

    typedef struct packed {
        logic [REAC_W-1:0] reaction;
        logic [ROW_W-1:0]  species;
        logic [COL_W-1:0]  column;
        logic              fault;
    } t_out_beat;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_div_ctl;
endpackage

// ===== design/tlps_if.sv =====
// valid/ready channel interface for the sampler
// depends on tlps_pkg for nothing but is generic over the payload type
interface tlps_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/tlps_ram.sv =====
// generic single-port synchronous ram with registered read
// no dependencies
module tlps_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_addr,
    input  logic [W-1:0]         i_wdata,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== design/tlps_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle
// depends on tlps_pkg
module tlps_div import tlps_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [VAL_W-1:0] i_num,
    input  logic [CNT_W-1:0] i_den,
    output logic             o_done,
    output logic [VAL_W-1:0] o_quot
);
    logic [VAL_W-1:0] r_q, n_q;
    logic [CNT_W:0]   r_rem, n_rem;
    logic [CNT_W-1:0] r_den;
    logic [5:0]       r_cnt, n_cnt;
    logic             r_busy, n_busy, r_done, n_done;
    logic [CNT_W:0]   w_sh;

    assign w_sh = {r_rem[CNT_W-1:0], r_q[VAL_W-1]};

    always_comb begin
        n_q = r_q; n_rem = r_rem; n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0;
        if (i_start) begin
            n_q = i_num; n_rem = '0; n_cnt = 6'(VAL_W); n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_sh >= {1'b0, r_den}) begin
                n_rem = w_sh - {1'b0, r_den};
                n_q   = {r_q[VAL_W-2:0], 1'b1};
            end else begin
                n_rem = w_sh;
                n_q   = {r_q[VAL_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_q <= n_q; r_rem <= n_rem;
        if (i_start) r_den <= i_den;
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

// ===== design/two_level_propensity_sampler_unit.sv =====
// Two-level propensity sampler: partial-propensity direct method selection.
// Channels: in_ch (sink) carries write and sample beats; out_ch (source)
// carries one result beat per sample beat. Config: i_cfg_we/i_cfg_wdata
// write species_in_use, taken whenever i_cfg_we is high.
// A sample takes a multiply, a scan of one species per cycle (read latency
// of the group-sum ram pipelined), a 48-step divide, then a scan of one
// column per cycle and a reaction read. One item at a time; the scans are
// set by the single read port of each ram.
// The result sits in an output register; a new item is taken while it waits
// unless it is a sample, which waits until the result has gone.
// Reset clears control, row-length valid bits and species_in_use (to 64);
// the other tables are undefined until written. No clearing pass.
// If the receiver stalls, the result is held and no sample is started.
module two_level_propensity_sampler_unit import tlps_pkg::*; #(
    parameter int MAX_SPECIES   = DEF_MAX_SPECIES,
    parameter int MAX_ROW_LEN   = DEF_MAX_ROW_LEN,
    parameter int MAX_REACTIONS = DEF_MAX_REACTIONS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    tlps_if.sink             in_ch,
    tlps_if.source           out_ch
);
    localparam int SP_W  = $clog2(MAX_SPECIES);
    localparam int CL_W  = (MAX_ROW_LEN > 1) ? $clog2(MAX_ROW_LEN) : 1;
    localparam int TB_D  = MAX_SPECIES * MAX_ROW_LEN;
    localparam int TB_W  = $clog2(TB_D);
    localparam int LEN_W = $clog2(MAX_ROW_LEN + 1);
    localparam int RN_W  = $clog2(MAX_REACTIONS);

    localparam logic [3:0] S_IDLE = 4'd0, S_MUL = 4'd1, S_TGT = 4'd2, S_G1 = 4'd3,
        S_GPICK = 4'd4, S_GRD = 4'd5, S_DIVS = 4'd6, S_DIVW = 4'd7, S_P1 = 4'd8,
        S_PRD = 4'd9, S_RRD = 4'd10, S_OUT = 4'd11;

    t_in_beat w_in;
    assign w_in = in_ch.data;

    logic [3:0]        r_st, n_st;
    logic [CFG_W-1:0]  r_siu;
    logic [VAL_W-1:0]  r_tot;
    logic [RND_W-1:0]  r_rnd;
    logic [79:0]       r_pa, r_pb;
    logic [VAL_W-1:0]  r_tgt;
    logic [SUM_W-1:0]  r_sum, r_before;
    logic [SP_W:0]     r_i, r_n;
    logic [SP_W-1:0]   r_sel;
    logic [LEN_W:0]    r_j;
    logic [LEN_W-1:0]  r_len;
    logic [CL_W-1:0]   r_col;
    logic              r_fault, r_found;
    logic [MAX_SPECIES-1:0] r_lv;
    t_out_beat         r_out;
    logic              r_ov;

    logic              w_acc, w_wr;
    logic [SP_W-1:0]   w_row;
    logic [CL_W-1:0]   w_col;
    logic              w_rok, w_cok;

    assign w_row = SP_W'(w_in.row);
    assign w_col = CL_W'(w_in.col);
    assign w_rok = ({26'd0, w_in.row} < 32'(MAX_SPECIES));
    assign w_cok = ({28'd0, w_in.col} < 32'(MAX_ROW_LEN));
    assign in_ch.ready = (r_st == S_IDLE) && !(w_in.kind == K_SAMPLE && r_ov);
    assign w_acc = in_ch.valid && in_ch.ready;
    assign w_wr  = w_acc && w_rok;

    // ram ports
    logic [SP_W-1:0]  g_addr, c_addr, l_addr;
    logic [TB_W-1:0]  p_addr, x_addr;
    logic [VAL_W-1:0] g_rd, p_rd;
    logic [CNT_W-1:0] c_rd;
    logic [RN_W-1:0]  x_rd, x_wd;
    logic [LEN_W-1:0] l_rd, l_wd;
    logic [TB_W-1:0]  w_taddr, w_saddr, w_naddr;

    assign w_taddr = TB_W'(w_row * MAX_ROW_LEN + w_col);
    assign w_saddr = TB_W'(r_sel * MAX_ROW_LEN + r_col);
    assign w_naddr = TB_W'(r_sel * MAX_ROW_LEN + r_col + 1);
    assign g_addr  = (r_st == S_IDLE) ? w_row : r_i[SP_W-1:0];
    assign c_addr  = (r_st == S_IDLE) ? w_row : r_sel;
    assign l_addr  = (r_st == S_IDLE) ? w_row : r_sel;
    // the column scan reads one column ahead
    assign p_addr  = (r_st == S_IDLE) ? w_taddr : ((r_st == S_PRD) ? w_naddr : w_saddr);
    assign x_addr  = (r_st == S_IDLE) ? w_taddr : w_saddr;
    assign x_wd = (w_in.value >= VAL_W'(MAX_REACTIONS)) ? RN_W'(MAX_REACTIONS - 1)
                                                      : RN_W'(w_in.value);
    assign l_wd = (w_in.value > VAL_W'(MAX_ROW_LEN)) ? LEN_W'(MAX_ROW_LEN)
                                                     : LEN_W'(w_in.value);

    tlps_ram #(.W(VAL_W), .D(MAX_SPECIES)) u_grp (.i_clk, .i_we(w_wr && w_in.kind == K_GROUP),
        .i_addr(g_addr), .i_wdata(w_in.value), .o_rdata(g_rd));
    tlps_ram #(.W(CNT_W), .D(MAX_SPECIES)) u_cnt (.i_clk, .i_we(w_wr && w_in.kind == K_COUNT),
        .i_addr(c_addr), .i_wdata(w_in.value[CNT_W-1:0]), .o_rdata(c_rd));
    tlps_ram #(.W(LEN_W), .D(MAX_SPECIES)) u_len (.i_clk, .i_we(w_wr && w_in.kind == K_LEN),
        .i_addr(l_addr), .i_wdata(l_wd), .o_rdata(l_rd));
    tlps_ram #(.W(VAL_W), .D(TB_D)) u_part (.i_clk,
        .i_we(w_wr && w_cok && w_in.kind == K_PART),
        .i_addr(p_addr), .i_wdata(w_in.value), .o_rdata(p_rd));
    tlps_ram #(.W(RN_W), .D(TB_D)) u_reac (.i_clk,
        .i_we(w_wr && w_cok && w_in.kind == K_REAC),
        .i_addr(x_addr), .i_wdata(x_wd), .o_rdata(x_rd));

    // divider
    t_div_ctl         w_dc;
    logic [VAL_W-1:0] w_quot;
    logic [CNT_W-1:0] w_den;
    assign w_den = (c_rd == '0) ? CNT_W'(1) : c_rd;
    assign w_dc.start = (r_st == S_DIVS);
    assign w_dc.busy  = (r_st == S_DIVW);
    tlps_div u_div (.i_clk, .i_rst_n, .i_start(w_dc.start),
        .i_num(VAL_W'({16'd0, r_tgt} - r_before)), .i_den(w_den),
        .o_done(w_dc.done), .o_quot(w_quot));

    logic [VAL_W-1:0] r_quot;
    logic [SUM_W-1:0] w_gsum, w_psum;
    assign w_gsum = r_sum + {16'd0, g_rd};
    assign w_psum = r_sum + {16'd0, p_rd};

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE:  if (w_acc && w_in.kind == K_SAMPLE) n_st = S_MUL;
            S_MUL:   n_st = S_TGT;
            S_TGT:   n_st = S_G1;
            S_G1:    n_st = S_GPICK;
            S_GPICK: if (r_found || r_i == r_n) n_st = S_GRD;
            S_GRD:   n_st = S_DIVS;
            S_DIVS:  n_st = S_DIVW;
            S_DIVW:  if (w_dc.done) n_st = S_P1;
            S_P1:    n_st = (r_len == '0) ? S_RRD : S_PRD;
            S_PRD:   if (r_found || r_j == {1'b0, r_len}) n_st = S_RRD;
            S_RRD:   n_st = S_OUT;
            S_OUT:   n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_siu <= CFG_W'(64); r_lv <= '0; r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            if (i_cfg_we) r_siu <= i_cfg_wdata;
            if (w_wr && w_in.kind == K_LEN) r_lv[w_row] <= 1'b1;
            if (r_st == S_OUT) r_ov <= 1'b1;
            else if (out_ch.ready) r_ov <= 1'b0;
        end
        case (r_st)
            S_IDLE: begin
                r_tot <= w_in.value; r_rnd <= w_in.random;
                r_sum <= '0; r_before <= '0; r_i <= '0; r_fault <= 1'b0; r_found <= 1'b0;
                if (r_siu == '0) r_n <= (SP_W+1)'(1);
                else if ({25'd0, r_siu} > 32'(MAX_SPECIES)) r_n <= (SP_W+1)'(MAX_SPECIES);
                else r_n <= (SP_W+1)'(r_siu);
            end
            S_MUL: begin
                r_pa <= 80'(r_rnd * r_tot[47:24]);
                r_pb <= 80'(r_rnd * r_tot[23:0]);
            end
            S_TGT: begin
                r_tgt <= VAL_W'((r_pa >> 8) + ((({72'd0, r_pa[7:0]} << 24) + r_pb) >> 32));
            end
            S_G1: begin
                r_i <= r_i + 1'b1;
            end
            S_GPICK: begin
                if (!r_found && r_i <= r_n) begin
                    r_before <= r_sum; r_sum <= w_gsum;
                    r_sel <= SP_W'(r_i - 1'b1);
                    if ({16'd0, r_tgt} < w_gsum) r_found <= 1'b1;
                    else if (r_i == r_n) r_fault <= 1'b1;
                    r_i <= r_i + 1'b1;
                end
            end
            S_GRD: ;
            S_DIVS: begin
                if (c_rd == '0) r_fault <= 1'b1;
                r_len <= r_lv[r_sel] ? l_rd : '0;
            end
            S_DIVW: begin
                r_quot <= w_quot; r_sum <= '0; r_j <= '0; r_col <= '0; r_found <= 1'b0;
            end
            S_P1: begin
                r_col <= '0;
                if (r_len == '0) r_fault <= 1'b1;
            end
            S_PRD: begin
                if (!r_found && r_j != {1'b0, r_len}) begin
                    r_sum <= w_psum;
                    r_j <= r_j + 1'b1;
                    if ({16'd0, r_quot} < w_psum) r_found <= 1'b1;
                    else if (r_j + 1'b1 == {1'b0, r_len}) r_fault <= 1'b1;
                    else r_col <= r_col + 1'b1;
                end
            end
            S_RRD: ;
            S_OUT: begin
                r_out.reaction <= REAC_W'(x_rd);
                r_out.species  <= ROW_W'(r_sel);
                r_out.column   <= COL_W'(r_col);
                r_out.fault    <= r_fault;
            end
            default: ;
        endcase
    end

    assign out_ch.valid = r_ov;
    assign out_ch.data  = r_out;
endmodule

// ===== design/tlps_check.sv =====
// port-level checker for the sampler, bound to the top level
// depends on tlps_pkg and the top level's ports
module tlps_check import tlps_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input t_in_beat  in_data,
    input logic      out_valid,
    input logic      out_ready,
    input t_out_beat out_data
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out hold");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid) else $error("valid after reset");
    a_samp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready && in_data.kind == K_SAMPLE |=> !in_ready)
        else $error("sample overlap");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready && in_data.kind == K_SAMPLE |=> !out_valid || $past(out_valid))
        else $error("early result");
endmodule

bind two_level_propensity_sampler_unit tlps_check u_check (
    .i_clk, .i_rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data));

// ===== dv/tb_two_level_propensity_sampler_unit.sv =====
// testbench for the two-level propensity sampler unit
// depends on tlps_pkg, tlps_if and two_level_propensity_sampler_unit
// table writes and samples are driven with random idling; expected draws are checked per beat
module tb_two_level_propensity_sampler_unit;
    import tlps_pkg::*;

    localparam int NSPEC = DEF_MAX_SPECIES;
    localparam int NCOL  = DEF_MAX_ROW_LEN;
    localparam int NREAC = DEF_MAX_REACTIONS;
    // columns filled in every row; one row is filled in full
    localparam int FILL_COLS = 4;
    localparam int FULL_ROW  = 7;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    tlps_if #(.T(t_in_beat))  in_ch ();
    tlps_if #(.T(t_out_beat)) out_ch ();

    two_level_propensity_sampler_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    // predictor state
    logic [VAL_W-1:0]  grp_tab [NSPEC];
    logic [VAL_W-1:0]  part_tab [NSPEC*NCOL];
    logic [CNT_W-1:0]  cnt_tab [NSPEC];
    logic [REAC_W-1:0] reac_tab [NSPEC*NCOL];
    int                len_tab [NSPEC];
    int                spec_used;

    t_out_beat draws_due [$];
    int        send_idle_pct;
    int        recv_stall_pct;
    bit        failed;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic t_out_beat predict_draw(logic [VAL_W-1:0] total,
                                               logic [RND_W-1:0] rnd);
        t_out_beat r;
        logic [SUM_W+16-1:0] prod;
        logic [SUM_W-1:0] target, start_sum, run_sum, quot;
        logic [CNT_W-1:0] c;
        int n, i, j, len;
        bit hit, flt;
        prod = rnd * {16'd0, total};
        target = prod >> 32;
        n = spec_used < 1 ? 1 : (spec_used > NSPEC ? NSPEC : spec_used);
        run_sum = 0;
        start_sum = 0;
        hit = 0;
        flt = 0;
        for (i = 0; i < n; i++) begin
            start_sum = run_sum;
            run_sum += grp_tab[i];
            if (target < run_sum) begin
                hit = 1;
                break;
            end
        end
        if (!hit) begin
            i = n - 1;
            flt = 1;
        end
        c = cnt_tab[i];
        if (c == 0) begin
            c = 1;
            flt = 1;
        end
        quot = (target - start_sum) / c;
        len = len_tab[i];
        run_sum = 0;
        hit = 0;
        for (j = 0; j < len; j++) begin
            run_sum += part_tab[i*NCOL+j];
            if (quot < run_sum) begin
                hit = 1;
                break;
            end
        end
        if (!hit) begin
            j = len == 0 ? 0 : len - 1;
            flt = 1;
        end
        r.reaction = reac_tab[i*NCOL+j];
        r.species  = i[ROW_W-1:0];
        r.column   = j[COL_W-1:0];
        r.fault    = flt;
        return r;
    endfunction

    task automatic send_beat(logic [KIND_W-1:0] kind, int row, int col,
                             logic [VAL_W-1:0] value, logic [RND_W-1:0] rnd);
        t_in_beat b;
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        b.kind = kind;
        b.row = row[ROW_W-1:0];
        b.col = col[COL_W-1:0];
        b.value = value;
        b.random = rnd;
        in_ch.valid <= 1'b1;
        in_ch.data  <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        case (kind)
            K_GROUP: grp_tab[row] = value;
            K_PART:  part_tab[row*NCOL+col] = value;
            K_COUNT: cnt_tab[row] = value[CNT_W-1:0];
            K_REAC:  reac_tab[row*NCOL+col] = value >= NREAC ? NREAC - 1 : value[REAC_W-1:0];
            K_LEN:   len_tab[row] = value > NCOL ? NCOL : int'(value);
            K_SAMPLE: draws_due.push_back(predict_draw(value, rnd));
            default: ;
        endcase
    endtask

    // result checker
    initial begin
        t_out_beat got, want;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                if (draws_due.size() == 0) begin
                    $error("result beat with nothing expected");
                    failed = 1;
                end else begin
                    want = draws_due.pop_front();
                    if (got.reaction !== want.reaction) begin
                        $error("reaction exp %0d got %0d", want.reaction, got.reaction);
                        failed = 1;
                    end
                    if (got.species !== want.species) begin
                        $error("species exp %0d got %0d", want.species, got.species);
                        failed = 1;
                    end
                    if (got.column !== want.column) begin
                        $error("column exp %0d got %0d", want.column, got.column);
                        failed = 1;
                    end
                    if (got.fault !== want.fault) begin
                        $error("fault exp %0d got %0d", want.fault, got.fault);
                        failed = 1;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (draws_due.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic set_species_used(int n);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= n[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        spec_used = n;
    endtask

    // row lengths stay within the filled columns so no sample reads an unwritten entry
    task automatic fill_tables(int mode, bit all_cols);
        for (int r = 0; r < NSPEC; r++) begin
            send_beat(K_GROUP, r, 0, mode == 0 ? 48'(64'h10000 * (1 + r % 4))
                                    : 48'({$urandom, $urandom}), 0);
            send_beat(K_COUNT, r, 0, mode == 0 ? 48'(1 + r % 3) : 48'($urandom_range(7)), 0);
            send_beat(K_LEN, r, 0, 48'($urandom_range(FILL_COLS)), 0);
            if (all_cols) begin
                for (int c = 0; c < FILL_COLS; c++) begin
                    send_beat(K_PART, r, c, 48'($urandom_range(32'h40000)), 0);
                    send_beat(K_REAC, r, c, 48'($urandom_range(1100)), 0);
                end
            end
        end
    endtask

    task automatic test_directed();
        fill_tables(0, 1);
        send_beat(K_SAMPLE, 0, 0, 48'h0, 32'd1);
        send_beat(K_SAMPLE, 0, 0, '1, '1);
        send_beat(K_SAMPLE, 0, 0, '1, 32'd1);
        send_beat(K_SAMPLE, 0, 0, 48'h10000, 32'h8000_0000);
        send_beat(K_COUNT, 3, 0, 48'h1_0000_0000, 0);
        send_beat(K_LEN, 5, 0, 48'd0, 0);
        send_beat(K_REAC, 5, 0, '1, 0);
        for (int c = FILL_COLS; c < NCOL; c++) begin
            send_beat(K_PART, FULL_ROW, c, 48'($urandom_range(32'h40000)), 0);
            send_beat(K_REAC, FULL_ROW, c, 48'($urandom_range(1100)), 0);
        end
        send_beat(K_LEN, FULL_ROW, 0, '1, 0);
        send_beat(3'd6, 1, 1, '1, '1);
        send_beat(3'd7, 2, 2, 48'd5, 32'd5);
        for (int k = 0; k < 8; k++)
            send_beat(K_SAMPLE, 0, 0, 48'(64'h10000 * k * 20), $urandom);
        set_species_used(1);
        send_beat(K_SAMPLE, 0, 0, '1, '1);
        set_species_used(0);
        send_beat(K_SAMPLE, 0, 0, 48'h10000, 32'h4000_0000);
        set_species_used(127);
        send_beat(K_SAMPLE, 0, 0, '1, '1);
    endtask

    task automatic test_random(int items, int mode);
        int k;
        logic [KIND_W-1:0] kind;
        int row;
        logic [VAL_W-1:0] val;
        for (k = 0; k < items; k++) begin
            if ($urandom_range(99) < 70)
                send_beat(K_SAMPLE, 0, 0, mode == 0 ? 48'($urandom_range(32'h00C0_0000))
                          : 48'({$urandom, $urandom}), $urandom_range(32'hFFFF_FFFF, 1));
            else begin
                kind = 3'($urandom_range(7));
                row = $urandom_range(63);
                val = 48'({$urandom, $urandom}) >> $urandom_range(47);
                if (kind == K_LEN && row != FULL_ROW)
                    val = 48'($urandom_range(FILL_COLS));
                send_beat(kind, row, $urandom_range(15), val, $urandom);
            end
        end
    endtask

    initial begin
        failed = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        spec_used = NSPEC;
        foreach (len_tab[r]) len_tab[r] = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        set_species_used(64);
        test_random(120, 0);
        send_idle_pct = 73;
        set_species_used(17);
        test_random(120, 0);
        send_idle_pct = 0;
        recv_stall_pct = 73;
        set_species_used(2);
        fill_tables(1, 0);
        test_random(100, 1);
        send_idle_pct = 9;
        recv_stall_pct = 9;
        set_species_used(40);
        fill_tables(0, 0);
        test_random(120, 0);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_species_used(64);
        test_random(100, 0);
        drain();
        if (failed == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
